// ===== src/rgb_to_cie_xy_converter_assert.svh =====
// Assertion macros for the RGB to CIE xy converter.
// Included by the modules that check their own logic; no other dependencies.
`ifndef RGB_TO_CIE_XY_CONVERTER_ASSERT_SVH
`define RGB_TO_CIE_XY_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
`define RCX_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RCX_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RCX_ASSERT(lbl, clk, rstn, prop, msg)
`define RCX_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ===== src/rcx_pkg.sv =====
// Shared widths, matrix coefficients and linearization tables of the converter.
// No dependencies.
package rcx_pkg;

    localparam int PIX_W  = 8;
    localparam int LIN_W  = 17;
    localparam int COEF_W = 17;
    localparam int PROD_W = LIN_W + COEF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int CHR_W  = 16;
    localparam int LUM_W  = 8;

    typedef logic [LIN_W-1:0]  t_lin;
    typedef logic [COEF_W-1:0] t_coef;
    typedef t_lin t_lut [256];
    typedef t_coef t_row [3];
    typedef t_row t_mat [3];

    localparam t_mat MAT_COEF = '{
        '{17'd42594, 17'd6780,  17'd12918},
        '{17'd15357, 17'd48698, 17'd1481},
        '{17'd0,     17'd3478,  17'd67880}
    };

    function automatic t_lut f_linear_lut();
        t_lut t;
        for (int c = 0; c < 256; c++) begin
            t[c] = LIN_W'((131072 * c + 255) / 510);
        end
        return t;
    endfunction

    function automatic t_lut f_gamma_lut();
        t_lut t;
        real  b;
        for (int c = 0; c < 256; c++) begin
            if (c <= 10) begin
                t[c] = LIN_W'((1310720 * c + 32946) / 65892);
            end else begin
                b    = (1000.0 * c + 14025.0) / 269025.0;
                t[c] = LIN_W'($rtoi(65536.0 * (b ** 2.4) + 0.5));
            end
        end
        return t;
    endfunction

    localparam t_lut LINEAR_LUT = f_linear_lut();
    localparam t_lut GAMMA_LUT  = f_gamma_lut();

endpackage

// ===== src/rcx_pixel_if.sv =====
// Pixel input channel: valid, ready and the 8-bit RGB item.
// Uses rcx_pkg for field widths.
interface rcx_pixel_if;
    logic                     valid;
    logic                     ready;
    logic [rcx_pkg::PIX_W-1:0] red_in;
    logic [rcx_pkg::PIX_W-1:0] green_in;
    logic [rcx_pkg::PIX_W-1:0] blue_in;
    modport source (output valid, red_in, green_in, blue_in, input ready);
    modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

// ===== src/rcx_chroma_if.sv =====
// Result channel: valid, ready, xy chromaticity and brightness.
// Uses rcx_pkg for field widths.
interface rcx_chroma_if;
    logic                     valid;
    logic                     ready;
    logic [rcx_pkg::CHR_W-1:0] x_chroma;
    logic [rcx_pkg::CHR_W-1:0] y_chroma;
    logic [rcx_pkg::LUM_W-1:0] luma_out;
    modport source (output valid, x_chroma, y_chroma, luma_out, input ready);
    modport sink (input valid, x_chroma, y_chroma, luma_out, output ready);
endinterface

// ===== src/rcx_cfg_if.sv =====
// Configuration write channel carrying the gamma enable bit.
// No dependencies.
interface rcx_cfg_if;
    logic valid;
    logic ready;
    logic gamma_enable;
    modport source (output valid, gamma_enable, input ready);
    modport sink (input valid, gamma_enable, output ready);
endinterface

// ===== src/rgb_to_cie_xy_converter.sv =====
// Top level of the RGB to CIE xy converter: front pipeline, divider cell row, output register.
// Depends on rcx_pkg, the three channel interfaces, rcx_front and rcx_div_cell.
//
//   channel | modport      | carries
//   i_pix   | pixel sink   | red_in, green_in, blue_in
//   o_chr   | chroma source| x_chroma, y_chroma, luma_out
//   i_cfg   | cfg sink     | gamma_enable, always ready
//
// One item per clock while o_chr is ready. The path holds three front stages,
// one divider cell per quotient bit (COORD_FRAC_BITS + 1 cells), one output register.
// Every stage loads when empty or when its successor loads, so bubbles close up.
// Synchronous active-low reset empties all stages and clears gamma_enable.
`include "rgb_to_cie_xy_converter_assert.svh"
module rgb_to_cie_xy_converter #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rcx_pixel_if.sink   i_pix,
    rcx_chroma_if.source o_chr,
    rcx_cfg_if.sink     i_cfg
);
    localparam int QW = COORD_FRAC_BITS + 1;
    localparam int NC = QW;

    logic                      r_gamma_en;
    logic                      v   [NC+1];
    logic                      ld  [NC+1];
    logic [rcx_pkg::SUM_W-1:0] s   [NC+1];
    logic [rcx_pkg::SUM_W-1:0] rx  [NC+1];
    logic [rcx_pkg::SUM_W-1:0] ry  [NC+1];
    logic [QW-1:0]             qx  [NC+1];
    logic [QW-1:0]             qy  [NC+1];
    logic [rcx_pkg::LUM_W-1:0] lum [NC+1];
    logic                      ld_out;
    logic                      r_out_valid;
    logic [rcx_pkg::CHR_W-1:0] r_out_x, r_out_y;
    logic [rcx_pkg::LUM_W-1:0] r_out_luma;
    logic [rcx_pkg::CHR_W-1:0] n_out_x, n_out_y;
    logic                      zero_s;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma_en <= 1'b0;
        end else if (i_cfg.valid) begin
            r_gamma_en <= i_cfg.gamma_enable;
        end
    end

    rcx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_gamma_en (r_gamma_en),
        .i_valid    (i_pix.valid),
        .o_ld       (i_pix.ready),
        .i_red      (i_pix.red_in),
        .i_green    (i_pix.green_in),
        .i_blue     (i_pix.blue_in),
        .o_valid    (v[0]),
        .i_ld_next  (ld[0]),
        .o_x        (rx[0]),
        .o_y        (ry[0]),
        .o_s        (s[0]),
        .o_luma     (lum[0])
    );

    assign qx[0] = '0;
    assign qy[0] = '0;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        rcx_div_cell #(
            .QW    (QW),
            .FIRST (k == 0)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (v[k]),
            .o_ld      (ld[k]),
            .i_ld_next (ld[k+1]),
            .o_valid   (v[k+1]),
            .i_s       (s[k]),
            .i_rem_x   (rx[k]),
            .i_rem_y   (ry[k]),
            .i_q_x     (qx[k]),
            .i_q_y     (qy[k]),
            .i_luma    (lum[k]),
            .o_s       (s[k+1]),
            .o_rem_x   (rx[k+1]),
            .o_rem_y   (ry[k+1]),
            .o_q_x     (qx[k+1]),
            .o_q_y     (qy[k+1]),
            .o_luma    (lum[k+1])
        );
    end

    assign ld_out  = !r_out_valid || o_chr.ready;
    assign ld[NC]  = ld_out;
    assign zero_s  = (s[NC] == '0);

    always_comb begin
        if (zero_s) begin
            n_out_x = '0;
            n_out_y = '0;
        end else begin
            n_out_x = (|(qx[NC] >> rcx_pkg::CHR_W)) ? '1 : rcx_pkg::CHR_W'(qx[NC]);
            n_out_y = (|(qy[NC] >> rcx_pkg::CHR_W)) ? '1 : rcx_pkg::CHR_W'(qy[NC]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld_out) begin
            r_out_valid <= v[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_out_x    <= n_out_x;
            r_out_y    <= n_out_y;
            r_out_luma <= lum[NC];
        end
    end

    assign o_chr.valid    = r_out_valid;
    assign o_chr.x_chroma = r_out_x;
    assign o_chr.y_chroma = r_out_y;
    assign o_chr.luma_out = r_out_luma;

    `RCX_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n |=> (!r_out_valid && !v[0]), "reset left an item in flight")
    `RCX_ASSERT(a_stall_full, i_clk, i_rst_n, !i_pix.ready |-> (o_chr.valid && !o_chr.ready), "input stalled with room in the row")
    `RCX_ASSERT(a_last_hold, i_clk, i_rst_n, (o_chr.valid && !o_chr.ready && v[NC]) |=> v[NC], "last cell dropped an item")
endmodule

// ===== src/rcx_front.sv =====
// Front pipeline: linearization lookup, matrix products, XYZ sums and brightness.
// Uses rcx_pkg for tables, coefficients and widths.
module rcx_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_gamma_en,
    input  logic                      i_valid,
    output logic                      o_ld,
    input  logic [rcx_pkg::PIX_W-1:0] i_red,
    input  logic [rcx_pkg::PIX_W-1:0] i_green,
    input  logic [rcx_pkg::PIX_W-1:0] i_blue,
    output logic                      o_valid,
    input  logic                      i_ld_next,
    output logic [rcx_pkg::SUM_W-1:0] o_x,
    output logic [rcx_pkg::SUM_W-1:0] o_y,
    output logic [rcx_pkg::SUM_W-1:0] o_s,
    output logic [rcx_pkg::LUM_W-1:0] o_luma
);
    logic                       r_va, r_vb, r_vc;
    logic                       ld_b, ld_c;
    rcx_pkg::t_lin              r_lin [3];
    logic [rcx_pkg::PROD_W-1:0] r_prod [3][3];
    logic [rcx_pkg::SUM_W-1:0]  r_x, r_y, r_s;
    logic [rcx_pkg::PIX_W-1:0]  pix [3];
    logic [rcx_pkg::SUM_W-1:0]  n_sum [3];
    logic [rcx_pkg::SUM_W+7:0]  y255;

    assign ld_c = !r_vc || i_ld_next;
    assign ld_b = !r_vb || ld_c;
    assign o_ld = !r_va || ld_b;

    assign pix[0] = i_red;
    assign pix[1] = i_green;
    assign pix[2] = i_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (o_ld) r_va <= i_valid;
            if (ld_b) r_vb <= r_va;
            if (ld_c) r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ld) begin
            for (int k = 0; k < 3; k++) begin
                r_lin[k] <= i_gamma_en ? rcx_pkg::GAMMA_LUT[pix[k]]
                                       : rcx_pkg::LINEAR_LUT[pix[k]];
            end
        end
        if (ld_b) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[r][k] <= rcx_pkg::PROD_W'(r_lin[k])
                                  * rcx_pkg::PROD_W'(rcx_pkg::MAT_COEF[r][k]);
                end
            end
        end
        if (ld_c) begin
            r_x <= n_sum[0];
            r_y <= n_sum[1];
            r_s <= n_sum[0] + n_sum[1] + n_sum[2];
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_sum[r] = rcx_pkg::SUM_W'(r_prod[r][0]) + rcx_pkg::SUM_W'(r_prod[r][1])
                     + rcx_pkg::SUM_W'(r_prod[r][2]);
        end
    end

    assign y255    = {r_y, 8'd0} - (rcx_pkg::SUM_W + 8)'(r_y);
    assign o_luma  = (|y255[rcx_pkg::SUM_W+7:40]) ? 8'hFF : y255[39:32];
    assign o_valid = r_vc;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_s     = r_s;
endmodule

// ===== src/rcx_div_cell.sv =====
// One divider cell: settles one quotient bit of X/S and Y/S and hands on the rest.
// Uses rcx_pkg for widths.
module rcx_div_cell #(
    parameter int QW    = 17,
    parameter bit FIRST = 1'b0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ld,
    input  logic                      i_ld_next,
    output logic                      o_valid,
    input  logic [rcx_pkg::SUM_W-1:0] i_s,
    input  logic [rcx_pkg::SUM_W-1:0] i_rem_x,
    input  logic [rcx_pkg::SUM_W-1:0] i_rem_y,
    input  logic [QW-1:0]             i_q_x,
    input  logic [QW-1:0]             i_q_y,
    input  logic [rcx_pkg::LUM_W-1:0] i_luma,
    output logic [rcx_pkg::SUM_W-1:0] o_s,
    output logic [rcx_pkg::SUM_W-1:0] o_rem_x,
    output logic [rcx_pkg::SUM_W-1:0] o_rem_y,
    output logic [QW-1:0]             o_q_x,
    output logic [QW-1:0]             o_q_y,
    output logic [rcx_pkg::LUM_W-1:0] o_luma
);
    logic                      r_v;
    logic [rcx_pkg::SUM_W-1:0] r_s, r_rem_x, r_rem_y;
    logic [QW-1:0]             r_q_x, r_q_y;
    logic [rcx_pkg::LUM_W-1:0] r_luma;
    logic [rcx_pkg::SUM_W:0]   sh_x, sh_y, s_ext;
    logic                      bit_x, bit_y;

    assign o_ld  = !r_v || i_ld_next;
    assign s_ext = {1'b0, i_s};
    assign sh_x  = FIRST ? {1'b0, i_rem_x} : {i_rem_x, 1'b0};
    assign sh_y  = FIRST ? {1'b0, i_rem_y} : {i_rem_y, 1'b0};
    assign bit_x = sh_x >= s_ext;
    assign bit_y = sh_y >= s_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ld) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ld) begin
            r_s     <= i_s;
            r_rem_x <= rcx_pkg::SUM_W'(bit_x ? sh_x - s_ext : sh_x);
            r_rem_y <= rcx_pkg::SUM_W'(bit_y ? sh_y - s_ext : sh_y);
            r_q_x   <= {i_q_x[QW-2:0], bit_x};
            r_q_y   <= {i_q_y[QW-2:0], bit_y};
            r_luma  <= i_luma;
        end
    end

    assign o_valid = r_v;
    assign o_s     = r_s;
    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_q_x   = r_q_x;
    assign o_q_y   = r_q_y;
    assign o_luma  = r_luma;
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for rgb_to_cie_xy_converter: random and directed pixels with idling.
// Depends on rcx_pkg, rcx_pixel_if, rcx_chroma_if, rcx_cfg_if and the converter RTL.
// An exact integer predictor computes the expected xy chromaticity and brightness per pixel.
`timescale 1ns / 100ps
module tb_top;

    localparam int FRAC_BITS  = 16;
    localparam int LATENCY    = FRAC_BITS + 5;
    localparam int STALL_MAX  = 4;
    localparam int WDOG_LIMIT = 4000;

    typedef struct packed {
        logic [rcx_pkg::CHR_W-1:0] x_chroma;
        logic [rcx_pkg::CHR_W-1:0] y_chroma;
        logic [rcx_pkg::LUM_W-1:0] luma_out;
    } t_chroma;

    logic i_clk;
    logic i_rst_n;

    rcx_pixel_if  pix ();
    rcx_chroma_if chr ();
    rcx_cfg_if    cfg ();

    rgb_to_cie_xy_converter #(.COORD_FRAC_BITS(FRAC_BITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_chr   (chr),
        .i_cfg   (cfg)
    );

    t_chroma     chroma_q[$];
    int unsigned srgb_curve[256];
    logic        gamma_on;
    bit          send_idle;
    bit          recv_idle;
    int          err_cnt;
    int          quiet_cycles;
    int          stall_left;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // exact sRGB curve: largest m with (2m-1)^5 * D^12 <= 2^85 * N^12
    function automatic void build_srgb_curve();
        logic [383:0] den12;
        logic [383:0] rhs;
        logic [383:0] lhs;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  m;
        den12 = 1;
        for (int i = 0; i < 12; i++) den12 = den12 * 384'd269025;
        for (int c = 0; c < 256; c++) begin
            if (c <= 10) begin
                srgb_curve[c] = (1310720 * c + 32946) / 65892;
            end else begin
                rhs = 384'd1 << 85;
                for (int i = 0; i < 12; i++) rhs = rhs * (1000 * c + 14025);
                lo = 0;
                hi = 65536;
                while (lo < hi) begin
                    m   = lo + (hi - lo + 1) / 2;
                    lhs = den12;
                    for (int i = 0; i < 5; i++) lhs = lhs * (2 * m - 1);
                    if (lhs <= rhs) lo = m;
                    else hi = m - 1;
                end
                srgb_curve[c] = lo;
            end
        end
    endfunction

    function automatic t_chroma predict_chroma(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        longint unsigned lin[3];
        longint unsigned xyz[3];
        longint unsigned s;
        longint unsigned xc;
        longint unsigned yc;
        longint unsigned lum;
        logic [7:0]      ch[3];
        t_chroma         res;
        ch = '{r, g, b};
        for (int k = 0; k < 3; k++)
            lin[k] = gamma_on ? srgb_curve[ch[k]] : (131072 * ch[k] + 255) / 510;
        for (int i = 0; i < 3; i++) begin
            xyz[i] = 0;
            for (int k = 0; k < 3; k++) xyz[i] += lin[k] * rcx_pkg::MAT_COEF[i][k];
        end
        s = xyz[0] + xyz[1] + xyz[2];
        xc = 0;
        yc = 0;
        if (s != 0) begin
            xc = (xyz[0] << FRAC_BITS) / s;
            yc = (xyz[1] << FRAC_BITS) / s;
            if (xc > 65535) xc = 65535;
            if (yc > 65535) yc = 65535;
        end
        lum = (xyz[1] * 255) >> 32;
        if (lum > 255) lum = 255;
        res.x_chroma = xc[15:0];
        res.y_chroma = yc[15:0];
        res.luma_out = lum[7:0];
        return res;
    endfunction

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        gap = send_idle ? $urandom_range(0, STALL_MAX) : 0;
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix.valid    <= 1'b1;
        pix.red_in   <= r;
        pix.green_in <= g;
        pix.blue_in  <= b;
        do @(posedge i_clk); while (!pix.ready);
        chroma_q.push_back(predict_chroma(r, g, b));
        @(negedge i_clk);
    endtask

    task automatic drain();
        pix.valid <= 1'b0;
        while (chroma_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_gamma(logic en);
        drain();
        cfg.valid        <= 1'b1;
        cfg.gamma_enable <= en;
        do @(posedge i_clk); while (!cfg.ready);
        gamma_on = en;
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic test_directed_pixels();
        for (int g = 0; g < 2; g++) begin
            write_gamma(g[0]);
            send_pixel(8'd0, 8'd0, 8'd0);
            send_pixel(8'd255, 8'd255, 8'd255);
            send_pixel(8'd255, 8'd0, 8'd0);
            send_pixel(8'd0, 8'd255, 8'd0);
            send_pixel(8'd0, 8'd0, 8'd255);
            send_pixel(8'd1, 8'd0, 8'd0);
            send_pixel(8'd10, 8'd10, 8'd10);
            send_pixel(8'd11, 8'd11, 8'd11);
            send_pixel(8'd170, 8'd85, 8'd170);
            send_pixel(8'd0, 8'd1, 8'd1);
        end
    endtask

    task automatic test_random_pixels(logic en, int n, bit idle);
        write_gamma(en);
        send_idle = idle;
        recv_idle = idle;
        for (int i = 0; i < n; i++)
            send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    task automatic test_pause_until_empty();
        write_gamma(1'b1);
        for (int i = 0; i < 40; i++) begin
            send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
            if (i == 20) begin
                pix.valid <= 1'b0;
                while (chroma_q.size() != 0) @(negedge i_clk);
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (recv_idle && stall_left > 0) begin
            chr.ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            chr.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_chroma exp_v;
        if (i_rst_n && chr.valid && chr.ready) begin
            stall_left <= $urandom_range(0, STALL_MAX);
            if (chroma_q.size() == 0) begin
                $display("%0t: unexpected item x=%0d y=%0d luma=%0d", $time,
                         chr.x_chroma, chr.y_chroma, chr.luma_out);
                err_cnt++;
            end else begin
                exp_v = chroma_q.pop_front();
                if (chr.x_chroma !== exp_v.x_chroma) begin
                    $display("%0t: x_chroma exp %0d got %0d", $time, exp_v.x_chroma,
                             chr.x_chroma);
                    err_cnt++;
                end
                if (chr.y_chroma !== exp_v.y_chroma) begin
                    $display("%0t: y_chroma exp %0d got %0d", $time, exp_v.y_chroma,
                             chr.y_chroma);
                    err_cnt++;
                end
                if (chr.luma_out !== exp_v.luma_out) begin
                    $display("%0t: luma_out exp %0d got %0d", $time, exp_v.luma_out,
                             chr.luma_out);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pix.valid && pix.ready) || (chr.valid && chr.ready) || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        pix.valid        = 1'b0;
        pix.red_in       = '0;
        pix.green_in     = '0;
        pix.blue_in      = '0;
        chr.ready        = 1'b0;
        cfg.valid        = 1'b0;
        cfg.gamma_enable = 1'b0;
        gamma_on         = 1'b0;
        send_idle        = 1'b1;
        recv_idle        = 1'b1;
        err_cnt          = 0;
        quiet_cycles     = 0;
        stall_left       = 0;
        build_srgb_curve();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_pixels();
        test_random_pixels(1'b0, 350, 1'b1);
        test_random_pixels(1'b1, 350, 1'b1);
        test_pause_until_empty();
        test_random_pixels(1'b0, 100, 1'b0);
        test_random_pixels(1'b1, 100, 1'b0);
        drain();

        if (err_cnt == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/rcx_pkg.sv
src/rcx_pixel_if.sv
src/rcx_chroma_if.sv
src/rcx_cfg_if.sv
src/rcx_front.sv
src/rcx_div_cell.sv
src/rgb_to_cie_xy_converter.sv
tb/tb_top.sv
